// File: src/tree_ensemble_inference_macros.svh
// Assertion helpers, expect clk and rst_n in the enclosing scope.
`ifndef TREE_ENSEMBLE_INFERENCE_MACROS_SVH
`define TREE_ENSEMBLE_INFERENCE_MACROS_SVH

`ifndef SYNTHESIS
`define TEI_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("tei assertion failed");
`define TEI_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("tei assertion failed");
`else
`define TEI_ASSERT_IMP(lbl, a, b)
`define TEI_ASSERT_NXT(lbl, a, b)
`endif

`endif

// File: src/tei_pkg.sv
package tei_pkg;

  localparam logic [1:0] OP_WR_NODE = 2'd0;
  localparam logic [1:0] OP_WR_HDR  = 2'd1;
  localparam logic [1:0] OP_WR_FEAT = 2'd2;
  localparam logic [1:0] OP_RUN     = 2'd3;

  localparam logic [1:0] REG_NUM_TREES    = 2'd0;
  localparam logic [1:0] REG_NUM_CLASSES  = 2'd1;
  localparam logic [1:0] REG_NUM_FEATURES = 2'd2;

  localparam logic KIND_HIT   = 1'b0;
  localparam logic KIND_TOTAL = 1'b1;

  localparam logic signed [47:0] TOTAL_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] TOTAL_MIN = 48'sh8000_0000_0000;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [4:0]         tree_index;
    logic [7:0]         node_index;
    logic               is_leaf;
    logic [7:0]         feature_index;
    logic signed [31:0] value;
    logic [7:0]         left_child;
    logic [7:0]         right_child;
    logic [7:0]         leaf_number;
    logic [8:0]         leaf_count;
    logic [2:0]         tree_class;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [4:0]         index;
    logic [12:0]        leaf_position;
    logic signed [47:0] score;
    logic               last;
  } out_item_t;

  // left holds the leaf number for a leaf
  typedef struct packed {
    logic               leaf;
    logic [7:0]         feat;
    logic signed [31:0] value;
    logic [7:0]         left;
    logic [7:0]         right;
  } node_t;

  typedef struct packed {
    logic [8:0] leaf_count;
    logic [2:0] cls;
  } hdr_t;

  typedef struct packed {
    logic wr_node;
    logic wr_hdr;
    logic wr_feat;
    logic run_clr;
    logic tree_inc;
    logic node_rd_root;
    logic node_rd_child;
    logic feat_rd;
    logic hit;
    logic flush;
    logic cls_emit;
  } dp_cmd_t;

  typedef struct packed {
    logic tree_done;
    logic hdr_skip;
    logic node_leaf;
    logic leaf_bad;
    logic node_bad;
    logic child_bad;
    logic pend_valid;
    logic out_free;
    logic cls_done;
  } dp_status_t;

endpackage

// File: src/tei_ram.sv
module tei_ram #(
  parameter int W = 32,
  parameter int D = 256
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0]  waddr,
  input  logic [W-1:0]                        wdata,
  input  logic                                re,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0]  raddr,
  output logic [W-1:0]                        rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

// File: src/tei_datapath.sv
module tei_datapath #(
  parameter int TREES          = 32,
  parameter int NODES_PER_TREE = 256,
  parameter int FEATURES       = 256,
  parameter int CLASSES        = 8,
  parameter int MAX_DEPTH      = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tei_pkg::in_item_t   in_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [8:0]          cfg_data,
  input  tei_pkg::dp_cmd_t    cmd,
  output tei_pkg::dp_status_t st,
  output logic                out_valid,
  input  logic                out_stall,
  output tei_pkg::out_item_t  out_data
);
  import tei_pkg::*;

  localparam int ND   = TREES * NODES_PER_TREE;
  localparam int NAW  = ND > 1 ? $clog2(ND) : 1;
  localparam int FAW  = FEATURES > 1 ? $clog2(FEATURES) : 1;
  localparam int TIW  = TREES > 1 ? $clog2(TREES) : 1;
  localparam int CIW  = CLASSES > 1 ? $clog2(CLASSES) : 1;
  localparam int TCW  = $clog2(TREES + 1);
  localparam int CCW  = $clog2(CLASSES + 1);
  localparam int DW   = $clog2(MAX_DEPTH + 1);

  logic [5:0] num_trees_r;
  logic [3:0] num_classes_r;
  logic [8:0] num_features_r;

  hdr_t hdr_r [TREES];
  hdr_t hdr;

  logic [TCW-1:0] tree_r;
  logic [CCW-1:0] cls_r;
  logic [DW-1:0]  depth_r;
  logic [12:0]    offset_r;
  logic signed [47:0] tot_r [CLASSES];

  logic       pend_valid_r;
  out_item_t  pend_r;
  logic       out_valid_r;
  out_item_t  out_r;

  node_t          node_q;
  logic [31:0]    feat_q;
  logic [56:0]    node_rdata;
  logic [7:0]     next_node;
  logic           node_we;
  logic [NAW-1:0] node_waddr;
  logic [NAW-1:0] node_raddr;
  logic           feat_we;
  node_t          node_wdata;
  logic [CIW-1:0] tot_idx;
  logic signed [47:0] tot_rd;
  logic signed [48:0] sum;
  logic signed [47:0] sat;
  out_item_t      hit_item;
  logic           out_free;
  logic           out_load;

  // stores
  assign node_we = cmd.wr_node && (int'(in_data.tree_index) < TREES)
                   && (int'(in_data.node_index) < NODES_PER_TREE);
  assign node_waddr = NAW'(int'(in_data.tree_index) * NODES_PER_TREE
                           + int'(in_data.node_index));
  assign node_wdata = '{leaf:  in_data.is_leaf,
                        feat:  in_data.feature_index,
                        value: in_data.value,
                        left:  in_data.is_leaf ? in_data.leaf_number : in_data.left_child,
                        right: in_data.right_child};
  assign feat_we = cmd.wr_feat && (int'(in_data.feature_index) < FEATURES);

  assign next_node = ($signed(feat_q) < node_q.value) ? node_q.left : node_q.right;
  assign node_raddr = NAW'(int'(tree_r) * NODES_PER_TREE
                           + (cmd.node_rd_child ? int'(next_node) : 0));

  tei_ram #(.W(57), .D(ND)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .re    (cmd.node_rd_root || cmd.node_rd_child),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );
  assign node_q = node_rdata;

  tei_ram #(.W(32), .D(FEATURES)) u_feat_ram (
    .clk   (clk),
    .we    (feat_we),
    .waddr (FAW'(in_data.feature_index)),
    .wdata (in_data.value),
    .re    (cmd.feat_rd),
    .raddr (FAW'(node_q.feat)),
    .rdata (feat_q)
  );

  // status
  assign hdr = hdr_r[tree_r[TIW-1:0]];
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (cmd.hit && pend_valid_r) || cmd.flush || cmd.cls_emit;

  always_comb begin
    st.tree_done  = (int'(tree_r) >= int'(num_trees_r)) || (int'(tree_r) >= TREES);
    st.hdr_skip   = (hdr.leaf_count == 9'd0) || (int'(hdr.cls) >= int'(num_classes_r))
                    || (int'(hdr.cls) >= CLASSES);
    st.node_leaf  = node_q.leaf;
    st.leaf_bad   = {1'b0, node_q.left} >= hdr.leaf_count;
    st.node_bad   = (int'(depth_r) >= MAX_DEPTH) || (int'(node_q.feat) >= int'(num_features_r))
                    || (int'(node_q.feat) >= FEATURES);
    st.child_bad  = int'(next_node) >= NODES_PER_TREE;
    st.pend_valid = pend_valid_r;
    st.out_free   = out_free;
    st.cls_done   = (int'(cls_r) >= int'(num_classes_r)) || (int'(cls_r) >= CLASSES);
  end

  // class totals, one read port shared by accumulate and emit
  assign tot_idx = cmd.cls_emit ? cls_r[CIW-1:0] : CIW'(hdr.cls);
  assign tot_rd  = tot_r[tot_idx];
  assign sum = {tot_rd[47], tot_rd} + {{17{node_q.value[31]}}, node_q.value};
  always_comb begin
    if (sum[48] != sum[47]) sat = sum[48] ? TOTAL_MIN : TOTAL_MAX;
    else sat = sum[47:0];
  end

  always_comb begin
    hit_item.kind          = KIND_HIT;
    hit_item.index         = 5'(tree_r);
    hit_item.leaf_position = offset_r + {5'd0, node_q.left};
    hit_item.score         = '0;
    hit_item.last          = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_trees_r    <= 6'd0;
      num_classes_r  <= 4'd1;
      num_features_r <= 9'd1;
      for (int i = 0; i < TREES; i++) hdr_r[i] <= '0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      tree_r   <= '0;
      cls_r    <= '0;
      depth_r  <= '0;
      offset_r <= '0;
      for (int i = 0; i < CLASSES; i++) tot_r[i] <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_NUM_TREES:    num_trees_r    <= cfg_data[5:0];
          REG_NUM_CLASSES:  num_classes_r  <= cfg_data[3:0];
          REG_NUM_FEATURES: num_features_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.wr_hdr && int'(in_data.tree_index) < TREES)
        hdr_r[TIW'(in_data.tree_index)] <= '{leaf_count: in_data.leaf_count,
                                             cls: in_data.tree_class};

      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      if (cmd.run_clr) begin
        tree_r   <= '0;
        cls_r    <= '0;
        offset_r <= '0;
        for (int i = 0; i < CLASSES; i++) tot_r[i] <= '0;
      end
      if (cmd.tree_inc) tree_r <= tree_r + 1'b1;
      if (cmd.node_rd_root) depth_r <= '0;
      if (cmd.node_rd_child) depth_r <= depth_r + 1'b1;

      if (cmd.hit) begin
        if (pend_valid_r) out_r <= pend_r;
        pend_r       <= hit_item;
        pend_valid_r <= 1'b1;
        tot_r[tot_idx] <= sat;
        offset_r <= offset_r + {4'd0, hdr.leaf_count};
        tree_r   <= tree_r + 1'b1;
      end
      if (cmd.flush) begin
        out_r <= '{kind:          pend_r.kind,
                   index:         pend_r.index,
                   leaf_position: pend_r.leaf_position,
                   score:         pend_r.score,
                   last:          (num_classes_r == 4'd0)};
        pend_valid_r <= 1'b0;
      end
      if (cmd.cls_emit) begin
        out_r.kind          <= KIND_TOTAL;
        out_r.index         <= 5'(cls_r);
        out_r.leaf_position <= '0;
        out_r.score         <= tot_rd;
        out_r.last          <= (int'(cls_r) + 1 >= int'(num_classes_r))
                               || (int'(cls_r) + 1 >= CLASSES);
        cls_r <= cls_r + 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule

// File: src/tei_ctrl.sv
`include "tree_ensemble_inference_macros.svh"

module tei_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_opcode,
  input  tei_pkg::dp_status_t st,
  output tei_pkg::dp_cmd_t    cmd
);
  import tei_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TREE  = 3'd1;
  localparam logic [2:0] S_NODE  = 3'd2;
  localparam logic [2:0] S_FEAT  = 3'd3;
  localparam logic [2:0] S_HIT   = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;
  localparam logic [2:0] S_CLS   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       acc;

  assign in_stall = (state_r != S_IDLE);
  assign acc = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          unique case (in_opcode)
            OP_WR_NODE: cmd.wr_node = 1'b1;
            OP_WR_HDR:  cmd.wr_hdr  = 1'b1;
            OP_WR_FEAT: cmd.wr_feat = 1'b1;
            OP_RUN: begin
              cmd.run_clr = 1'b1;
              state_nxt = S_TREE;
            end
            default: ;
          endcase
        end
      end
      S_TREE: begin
        if (st.tree_done) state_nxt = S_FLUSH;
        else if (st.hdr_skip) cmd.tree_inc = 1'b1;
        else begin
          cmd.node_rd_root = 1'b1;
          state_nxt = S_NODE;
        end
      end
      S_NODE: begin
        if (st.node_leaf) begin
          if (st.leaf_bad) begin
            cmd.tree_inc = 1'b1;
            state_nxt = S_TREE;
          end else state_nxt = S_HIT;
        end else if (st.node_bad) begin
          cmd.tree_inc = 1'b1;
          state_nxt = S_TREE;
        end else begin
          cmd.feat_rd = 1'b1;
          state_nxt = S_FEAT;
        end
      end
      S_FEAT: begin
        if (st.child_bad) begin
          cmd.tree_inc = 1'b1;
          state_nxt = S_TREE;
        end else begin
          cmd.node_rd_child = 1'b1;
          state_nxt = S_NODE;
        end
      end
      S_HIT: begin
        // previous hit goes out only now that it is known not to be last
        if (!st.pend_valid || st.out_free) begin
          cmd.hit = 1'b1;
          state_nxt = S_TREE;
        end
      end
      S_FLUSH: begin
        if (!st.pend_valid) state_nxt = S_CLS;
        else if (st.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_CLS;
        end
      end
      S_CLS: begin
        if (st.cls_done) state_nxt = S_IDLE;
        else if (st.out_free) cmd.cls_emit = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  `TEI_ASSERT_IMP(a_hit_room, cmd.hit && st.pend_valid, st.out_free)
  `TEI_ASSERT_IMP(a_cls_room, cmd.cls_emit || cmd.flush, st.out_free)
  `TEI_ASSERT_IMP(a_node_after_read, state_r == S_NODE,
                  $past(state_r) == S_TREE || $past(state_r) == S_FEAT)
  `TEI_ASSERT_NXT(a_run_starts, cmd.run_clr, state_r == S_TREE)
endmodule

// File: src/tree_ensemble_inference.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_stall    in_data  (in_item_t)
// out       output     out_valid / out_stall  out_data (out_item_t)
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Write transactions are accepted only in idle. A run is accepted, then steps through each tree index,
// each node visited and each level descended, and each kept tree; it then closes the walk, emits
// each class result and returns to idle; node and feature memory reads
// (one per cycle, registered) set the walk cost.
// Synchronous active-low reset clears registers and tree headers; no clearing pass.
// Output stalls hold the walk only when a result needs the output register.
module tree_ensemble_inference #(
  parameter int TREES          = 32,
  parameter int NODES_PER_TREE = 256,
  parameter int FEATURES       = 256,
  parameter int CLASSES        = 8,
  parameter int MAX_DEPTH      = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tei_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tei_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data
);
  import tei_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  assign cfg_ready = 1'b1;

  tei_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_data.opcode),
    .st        (st),
    .cmd       (cmd)
  );

  tei_datapath #(
    .TREES          (TREES),
    .NODES_PER_TREE (NODES_PER_TREE),
    .FEATURES       (FEATURES),
    .CLASSES        (CLASSES),
    .MAX_DEPTH      (MAX_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );
endmodule
